[rtl/pst_pkg.sv]
`timescale 1ns / 1ps

package pst_pkg;

  // Token kinds as they appear on the result channel
  typedef enum logic [4:0] {
    TK_END      = 5'd0,
    TK_IDENT    = 5'd1,
    TK_INTEGER  = 5'd2,
    TK_REAL     = 5'd3,
    TK_STRING   = 5'd4,
    TK_KEYWORD  = 5'd5,
    TK_PLUS     = 5'd6,
    TK_MINUS    = 5'd7,
    TK_STAR     = 5'd8,
    TK_SLASH    = 5'd9,
    TK_ASSIGN   = 5'd10,
    TK_COLON    = 5'd11,
    TK_SEMI     = 5'd12,
    TK_COMMA    = 5'd13,
    TK_LPAREN   = 5'd14,
    TK_RPAREN   = 5'd15,
    TK_LBRACK   = 5'd16,
    TK_RBRACK   = 5'd17,
    TK_RANGE    = 5'd18,
    TK_DOT      = 5'd19,
    TK_UNKNOWN  = 5'd20,
    TK_UNTERM   = 5'd21
  } tok_kind_t;

  // Scanner mode between characters
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_NAME     = 3'd1,
    MODE_NUMBER   = 3'd2,
    MODE_TEXT     = 3'd3,
    MODE_OPERATOR = 3'd4
  } scan_mode_t;

  // First half of a two-character operator
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_COLON = 2'd1,
    OP_DOT   = 2'd2
  } pend_op_t;

  // Keyword codes
  localparam logic [3:0] KW_BEGIN     = 4'd0;
  localparam logic [3:0] KW_END       = 4'd1;
  localparam logic [3:0] KW_IF        = 4'd2;
  localparam logic [3:0] KW_THEN      = 4'd3;
  localparam logic [3:0] KW_ELSE      = 4'd4;
  localparam logic [3:0] KW_WHILE     = 4'd5;
  localparam logic [3:0] KW_DO        = 4'd6;
  localparam logic [3:0] KW_PROGRAM   = 4'd7;
  localparam logic [3:0] KW_VAR       = 4'd8;
  localparam logic [3:0] KW_PROCEDURE = 4'd9;
  localparam logic [3:0] KW_FUNCTION  = 4'd10;

  localparam int         KW_COUNT   = 11;
  localparam int         KW_MAX_LEN = 9;
  localparam logic [10:0] KW_ALL    = 11'h7FF;

  // Character codes
  localparam logic [20:0] CH_NUL    = 21'd0;
  localparam logic [20:0] CH_TAB    = 21'd9;
  localparam logic [20:0] CH_LF     = 21'd10;
  localparam logic [20:0] CH_CR     = 21'd13;
  localparam logic [20:0] CH_SPACE  = 21'd32;
  localparam logic [20:0] CH_QUOTE  = 21'd39;
  localparam logic [20:0] CH_LPAREN = 21'd40;
  localparam logic [20:0] CH_RPAREN = 21'd41;
  localparam logic [20:0] CH_STAR   = 21'd42;
  localparam logic [20:0] CH_PLUS   = 21'd43;
  localparam logic [20:0] CH_COMMA  = 21'd44;
  localparam logic [20:0] CH_MINUS  = 21'd45;
  localparam logic [20:0] CH_DOT    = 21'd46;
  localparam logic [20:0] CH_SLASH  = 21'd47;
  localparam logic [20:0] CH_ZERO   = 21'd48;
  localparam logic [20:0] CH_NINE   = 21'd57;
  localparam logic [20:0] CH_COLON  = 21'd58;
  localparam logic [20:0] CH_SEMI   = 21'd59;
  localparam logic [20:0] CH_EQUAL  = 21'd61;
  localparam logic [20:0] CH_UC_A   = 21'd65;
  localparam logic [20:0] CH_UC_Z   = 21'd90;
  localparam logic [20:0] CH_LBRACK = 21'd91;
  localparam logic [20:0] CH_RBRACK = 21'd93;
  localparam logic [20:0] CH_UNDER  = 21'd95;
  localparam logic [20:0] CH_LC_A   = 21'd97;
  localparam logic [20:0] CH_LC_Z   = 21'd122;

  // One result token
  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  kw;
    logic [15:0] line;
    logic [15:0] col;
    logic [10:0] len;
    logic        last;
  } tok_t;

  // Tokens caused by the character at the scanner input
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } scan_out_t;

  // Keyword spelling, right-aligned in 72 bits
  function automatic logic [71:0] kw_text(input logic [3:0] k);
    logic [71:0] s;
    unique case (k)
      KW_BEGIN:     s = 72'("begin");
      KW_END:       s = 72'("end");
      KW_IF:        s = 72'("if");
      KW_THEN:      s = 72'("then");
      KW_ELSE:      s = 72'("else");
      KW_WHILE:     s = 72'("while");
      KW_DO:        s = 72'("do");
      KW_PROGRAM:   s = 72'("program");
      KW_VAR:       s = 72'("var");
      KW_PROCEDURE: s = 72'("procedure");
      KW_FUNCTION:  s = 72'("function");
      default:      s = 72'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] l;
    unique case (k)
      KW_BEGIN:     l = 4'd5;
      KW_END:       l = 4'd3;
      KW_IF:        l = 4'd2;
      KW_THEN:      l = 4'd4;
      KW_ELSE:      l = 4'd4;
      KW_WHILE:     l = 4'd5;
      KW_DO:        l = 4'd2;
      KW_PROGRAM:   l = 4'd7;
      KW_VAR:       l = 4'd3;
      KW_PROCEDURE: l = 4'd9;
      KW_FUNCTION:  l = 4'd8;
      default:      l = 4'd0;
    endcase
    return l;
  endfunction

  // Character of keyword k at position pos, zero past its end
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] pos);
    logic [71:0] s;
    logic [3:0]  l;
    logic [3:0]  r;
    logic [7:0]  ch;
    s  = kw_text(k);
    l  = kw_len(k);
    r  = l - 4'd1 - pos;
    ch = 8'h00;
    if (pos < l) begin
      ch = s[{r, 3'b000} +: 8];
    end
    return ch;
  endfunction

  // Keywords whose character at pos equals c
  function automatic logic [10:0] kw_match(input logic [20:0] c, input logic [3:0] pos);
    logic [10:0] m;
    logic [7:0]  ch;
    for (int k = 0; k < KW_COUNT; k++) begin
      ch   = kw_char(4'(k), pos);
      m[k] = (ch != 8'h00) && (c == {13'd0, ch});
    end
    return m;
  endfunction

  // Kind of a character that forms a token by itself
  function automatic tok_kind_t single_kind(input logic [20:0] c);
    tok_kind_t t;
    unique case (c)
      CH_PLUS:   t = TK_PLUS;
      CH_MINUS:  t = TK_MINUS;
      CH_STAR:   t = TK_STAR;
      CH_SLASH:  t = TK_SLASH;
      CH_SEMI:   t = TK_SEMI;
      CH_COMMA:  t = TK_COMMA;
      CH_LPAREN: t = TK_LPAREN;
      CH_RPAREN: t = TK_RPAREN;
      CH_LBRACK: t = TK_LBRACK;
      CH_RBRACK: t = TK_RBRACK;
      default:   t = TK_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

[rtl/pst_scan.sv]
`timescale 1ns / 1ps

module pst_scan #(
  parameter int MAX_NAME_LENGTH = 255,
  parameter int MAX_TEXT_LENGTH = 1024,
  parameter int POSITION_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  logic [20:0]        code_point,
  input  logic               end_of_input,
  output pst_pkg::scan_out_t scan_out
);
  import pst_pkg::*;

  localparam int MAX_LEN = (MAX_NAME_LENGTH > MAX_TEXT_LENGTH) ? MAX_NAME_LENGTH
                                                               : MAX_TEXT_LENGTH;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int PW      = POSITION_BITS;

  localparam logic [LEN_W-1:0] NAME_MAX = LEN_W'(MAX_NAME_LENGTH);
  localparam logic [LEN_W-1:0] TEXT_MAX = LEN_W'(MAX_TEXT_LENGTH);
  localparam logic [LEN_W-1:0] KW_LIMIT = LEN_W'(KW_MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
  localparam logic [PW-1:0]    POS_MAX  = {PW{1'b1}};
  localparam logic [PW-1:0]    POS_ONE  = PW'(1);

  scan_mode_t       mode_r,  mode_nxt;
  pend_op_t         pend_r,  pend_nxt;
  logic [LEN_W-1:0] len_r,   len_nxt;
  logic [10:0]      cand_r,  cand_nxt;
  logic [PW-1:0]    sline_r, sline_nxt;
  logic [PW-1:0]    scol_r,  scol_nxt;
  logic [PW-1:0]    line_r,  line_nxt;
  logic [PW-1:0]    col_r,   col_nxt;
  logic             seen_r,  seen_nxt;
  logic             stop_r,  stop_nxt;

  // Character classes
  logic eoi, is_letter, is_numeral, is_space;
  logic is_quote, is_colon, is_dot, is_equal, is_lf;

  always_comb begin
    eoi        = end_of_input || (code_point == CH_NUL);
    is_letter  = ((code_point >= CH_LC_A) && (code_point <= CH_LC_Z)) ||
                 ((code_point >= CH_UC_A) && (code_point <= CH_UC_Z)) ||
                 (code_point == CH_UNDER);
    is_numeral = (code_point >= CH_ZERO) && (code_point <= CH_NINE);
    is_space   = (code_point == CH_SPACE) ||
                 ((code_point >= CH_TAB) && (code_point <= CH_CR));
    is_quote   = code_point == CH_QUOTE;
    is_colon   = code_point == CH_COLON;
    is_dot     = code_point == CH_DOT;
    is_equal   = code_point == CH_EQUAL;
    is_lf      = code_point == CH_LF;
  end

  // Decide whether the pending token takes this character
  logic name_ext, num_ext, txt_close, txt_grow, op_match;
  logic consumed, t0_valid, fresh, end_tok;
  logic start_name, start_num, start_txt, start_colon, start_dot, start_any;
  logic fresh_single, t1_valid;

  always_comb begin
    name_ext  = (mode_r == MODE_NAME) && !eoi && (is_letter || is_numeral) &&
                (len_r < NAME_MAX);
    num_ext   = (mode_r == MODE_NUMBER) && !eoi && (is_numeral || (is_dot && !seen_r)) &&
                (len_r < NAME_MAX);
    txt_close = (mode_r == MODE_TEXT) && !eoi && is_quote;
    txt_grow  = (mode_r == MODE_TEXT) && !eoi && !is_quote && (len_r < TEXT_MAX);
    op_match  = (mode_r == MODE_OPERATOR) && !eoi &&
                (((pend_r == OP_COLON) && is_equal) || ((pend_r != OP_COLON) && is_dot));
    consumed  = name_ext || num_ext || txt_close || txt_grow || op_match;
    t0_valid  = ((mode_r == MODE_NAME) && !name_ext) ||
                ((mode_r == MODE_NUMBER) && !num_ext) ||
                ((mode_r == MODE_TEXT) && !txt_grow) ||
                (mode_r == MODE_OPERATOR);

    fresh        = !consumed && !eoi;
    end_tok      = !consumed && eoi;
    start_name   = fresh && is_letter;
    start_num    = fresh && is_numeral;
    start_txt    = fresh && is_quote;
    start_colon  = fresh && is_colon;
    start_dot    = fresh && is_dot;
    start_any    = start_name || start_num || start_txt || start_colon || start_dot;
    fresh_single = fresh && !is_space && !start_any;
    t1_valid     = end_tok || fresh_single;
  end

  // Keyword candidates left after this character
  logic        abs_pos_ok;
  logic [3:0]  abs_pos;
  logic [10:0] kw_hits;

  always_comb begin
    abs_pos_ok = start_name || (len_r < KW_LIMIT);
    abs_pos    = start_name ? 4'd0 : len_r[3:0];
    kw_hits    = kw_match(code_point, abs_pos) & {11{abs_pos_ok}};
  end

  // Find the keyword that a finished name spells, if any
  logic       kw_found;
  logic [3:0] kw_idx;

  always_comb begin
    kw_found = 1'b0;
    kw_idx   = KW_BEGIN;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!kw_found && cand_r[k] && (len_r == LEN_W'(kw_len(4'(k))))) begin
        kw_found = 1'b1;
        kw_idx   = 4'(k);
      end
    end
  end

  // Fit lengths and positions to the result field widths
  logic [LEN_W+10:0] len_ext;
  logic [PW+15:0]    sline_ext, scol_ext, line_ext, col_ext;
  logic [10:0]       len_out;
  logic [15:0]       sline_out, scol_out, line_out, col_out;

  always_comb begin
    len_ext   = {11'd0, len_r};
    sline_ext = {16'd0, sline_r};
    scol_ext  = {16'd0, scol_r};
    line_ext  = {16'd0, line_r};
    col_ext   = {16'd0, col_r};
    len_out   = len_ext[10:0];
    sline_out = sline_ext[15:0];
    scol_out  = scol_ext[15:0];
    line_out  = line_ext[15:0];
    col_out   = col_ext[15:0];
  end

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    len_nxt   = len_r;
    cand_nxt  = cand_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    seen_nxt  = seen_r;
    stop_nxt  = stop_r;
    if (commit && !stop_r) begin
      if (consumed) begin
        unique case (mode_r)
          MODE_NAME: begin
            len_nxt  = len_r + LEN_ONE;
            cand_nxt = cand_r & kw_hits;
          end
          MODE_NUMBER: begin
            len_nxt  = len_r + LEN_ONE;
            seen_nxt = seen_r | is_dot;
          end
          MODE_TEXT: begin
            if (txt_close) begin
              mode_nxt = MODE_IDLE;
            end else begin
              len_nxt = len_r + LEN_ONE;
            end
          end
          MODE_OPERATOR: begin
            mode_nxt = MODE_IDLE;
            pend_nxt = OP_NONE;
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end else begin
        mode_nxt = MODE_IDLE;
        pend_nxt = OP_NONE;
        if (end_tok) begin
          stop_nxt = 1'b1;
        end
        if (start_any) begin
          sline_nxt = line_r;
          scol_nxt  = col_r;
          len_nxt   = '0;
          cand_nxt  = KW_ALL;
          seen_nxt  = 1'b0;
        end
        priority if (start_name) begin
          mode_nxt = MODE_NAME;
          len_nxt  = LEN_ONE;
          cand_nxt = kw_hits;
        end else if (start_num) begin
          mode_nxt = MODE_NUMBER;
          len_nxt  = LEN_ONE;
        end else if (start_txt) begin
          mode_nxt = MODE_TEXT;
        end else if (start_colon) begin
          mode_nxt = MODE_OPERATOR;
          pend_nxt = OP_COLON;
        end else if (start_dot) begin
          mode_nxt = MODE_OPERATOR;
          pend_nxt = OP_DOT;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      // Advance the position counters, saturating
      if (!eoi) begin
        if (is_lf) begin
          if (line_r != POS_MAX) begin
            line_nxt = line_r + POS_ONE;
          end
          col_nxt = '0;
        end else if (col_r != POS_MAX) begin
          col_nxt = col_r + POS_ONE;
        end
      end
    end
  end

  // Tokens for the character at the input
  tok_t t0, t1;

  always_comb begin
    t0      = '0;
    t0.line = sline_out;
    t0.col  = scol_out;
    t0.len  = len_out;
    t0.last = !t1_valid;
    unique case (mode_r)
      MODE_NAME: begin
        t0.kind = kw_found ? TK_KEYWORD : TK_IDENT;
        t0.kw   = kw_found ? kw_idx : KW_BEGIN;
      end
      MODE_NUMBER: begin
        t0.kind = seen_r ? TK_REAL : TK_INTEGER;
      end
      MODE_TEXT: begin
        t0.kind = txt_close ? TK_STRING : TK_UNTERM;
      end
      MODE_OPERATOR: begin
        if (pend_r == OP_COLON) begin
          t0.kind = op_match ? TK_ASSIGN : TK_COLON;
        end else begin
          t0.kind = op_match ? TK_RANGE : TK_DOT;
        end
        t0.len = op_match ? 11'd2 : 11'd1;
      end
      default: begin
        t0.kind = TK_END;
      end
    endcase

    t1      = '0;
    t1.line = line_out;
    t1.col  = col_out;
    t1.last = 1'b1;
    if (end_tok) begin
      t1.kind = TK_END;
      t1.len  = 11'd0;
    end else begin
      t1.kind = single_kind(code_point);
      t1.len  = 11'd1;
    end

    scan_out.count  = stop_r ? 2'd0 : (2'(t0_valid) + 2'(t1_valid));
    scan_out.first  = t0_valid ? t0 : t1;
    scan_out.second = t1;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pend_r  <= OP_NONE;
      len_r   <= '0;
      cand_r  <= KW_ALL;
      sline_r <= POS_ONE;
      scol_r  <= '0;
      line_r  <= POS_ONE;
      col_r   <= '0;
      seen_r  <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      len_r   <= len_nxt;
      cand_r  <= cand_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      seen_r  <= seen_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

[rtl/pascal_style_token_scanner.sv]
`timescale 1ns / 1ps

// Pascal-style token scanner: takes one decoded character per transfer and
// returns tokens (kind, keyword code, start line and column, length) on the
// result stream. A character goes into an input register, is scanned from
// there, and its tokens land in a two-entry result queue that feeds the
// result port. The input side takes one character per clock while each
// character yields at most one token and the result side keeps up; a
// character that both ends a token and forms one itself yields two tokens
// and then waits until the queue is empty, since the result port moves one
// token per cycle while out_tready is high. After the end token every
// character is taken and dropped until reset.
module pascal_style_token_scanner #(
  parameter int MAX_NAME_LENGTH = 255,
  parameter int MAX_TEXT_LENGTH = 1024,
  parameter int POSITION_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] code_point, [23:21] zero
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [4:0] token_kind, [8:5] keyword_code,
                                  // [24:9] start_line, [40:25] start_column,
                                  // [51:41] lexeme_length, [55:52] zero
  output logic        out_tlast   // last_of_run
);
  import pst_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [20:0] in_code_r;
  logic        in_eoi_r;
  logic        in_xfer, adv, pop;

  scan_out_t   scan_out;
  tok_t        q_r   [2];
  tok_t        q_nxt [2];
  logic [1:0]  cnt_r, cnt_nxt, cnt_base;

  // Scan the registered character
  pst_scan #(
    .MAX_NAME_LENGTH (MAX_NAME_LENGTH),
    .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH),
    .POSITION_BITS   (POSITION_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .commit       (adv),
    .code_point   (in_code_r),
    .end_of_input (in_eoi_r),
    .scan_out     (scan_out)
  );

  // Advance the character once its tokens fit in the queue
  always_comb begin
    pop          = out_tvalid && out_tready;
    cnt_base     = cnt_r - 2'(pop);
    adv          = in_valid_r && ({1'b0, scan_out.count} <= (3'd2 - {1'b0, cnt_base}));
    in_tready    = !in_valid_r || adv;
    in_xfer      = in_tvalid && in_tready;
    in_valid_nxt = in_xfer || (in_valid_r && !adv);
  end

  // Shift out the head, then append new tokens behind what remains
  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = cnt_base;
    if (pop) begin
      q_nxt[0] = q_r[1];
    end
    if (adv) begin
      cnt_nxt = cnt_base + scan_out.count;
      if (cnt_base == 2'd0) begin
        q_nxt[0] = scan_out.first;
        q_nxt[1] = scan_out.second;
      end else if (cnt_base == 2'd1) begin
        q_nxt[1] = scan_out.first;
      end
    end
  end

  // Drive the result port from the queue head
  always_comb begin
    out_tvalid = cnt_r != 2'd0;
    out_tdata  = {4'd0, q_r[0].len, q_r[0].col, q_r[0].line, q_r[0].kw, q_r[0].kind};
    out_tlast  = q_r[0].last;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      in_valid_r <= in_valid_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_code_r <= in_tdata[20:0];
      in_eoi_r  <= in_tlast;
    end
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  // Queue never holds more than two tokens
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("result queue overfilled");

  // The end token never has another token after it from the same character
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && scan_out.count == 2'd2) |-> (scan_out.first.kind != TK_END))
    else $error("token follows end token");

  // An end token at the head always closes its run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && q_r[0].kind == TK_END) |-> out_tlast)
    else $error("end token not marked last");

  // A stalled character adds nothing to the queue; only a pop changes the count
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (cnt_r == $past(cnt_base)))
    else $error("queue changed while character stalled");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import pst_pkg::*;

  localparam int          NAME_CAP      = 255;
  localparam int          TEXT_CAP      = 1024;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [3:0]  NO_KW         = 4'd0;
  localparam int          RANDOM_CHARS  = 1050;
  localparam int          DRAIN_CAP     = 20000;
  localparam int          SETTLE_CYCLES = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = 24'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;

  pascal_style_token_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Tokens predicted for accepted characters, oldest first
  tok_t expected_tokens[$];
  int   fail_count = 0;
  int   chars_sent = 0;
  bit   calm       = 1'b0;
  int   ready_hold = 0;

  // Scanner state as the predictor tracks it
  logic [15:0] cur_line  = 16'd1;
  logic [15:0] cur_col   = 16'd0;
  scan_mode_t  cur_mode  = MODE_IDLE;
  logic [10:0] tok_len   = 11'd0;
  logic [10:0] kw_cands  = KW_ALL;
  logic [15:0] tok_line  = 16'd1;
  logic [15:0] tok_col   = 16'd0;
  logic        saw_point = 1'b0;
  pend_op_t    half_op   = OP_NONE;
  logic        scan_done = 1'b0;

  // Keyword spellings, indexed by keyword code
  string kw_words [KW_COUNT] = '{"begin", "end", "if", "then", "else", "while", "do",
                                 "program", "var", "procedure", "function"};

  function automatic bit is_letter(input logic [20:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
           c == CH_UNDER;
  endfunction

  function automatic bit is_numeral(input logic [20:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_space(input logic [20:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void add_token(input tok_kind_t kind, input logic [3:0] kw,
                                    input logic [15:0] ln, input logic [15:0] col,
                                    input logic [10:0] len);
    tok_t t;
    t.kind = kind;
    t.kw   = kw;
    t.line = ln;
    t.col  = col;
    t.len  = len;
    t.last = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void start_token(input scan_mode_t mode);
    cur_mode  = mode;
    tok_line  = cur_line;
    tok_col   = cur_col;
    tok_len   = 11'd0;
    kw_cands  = KW_ALL;
    saw_point = 1'b0;
    half_op   = OP_NONE;
  endfunction

  // Narrow the keyword candidates by the next name character
  function automatic void absorb_letter(input logic [20:0] c);
    for (int k = 0; k < KW_COUNT; k++) begin
      if (tok_len >= kw_words[k].len() || {13'd0, kw_words[k][tok_len]} != c) begin
        kw_cands[k] = 1'b0;
      end
    end
    tok_len = tok_len + 11'd1;
  endfunction

  function automatic void close_name();
    bit found;
    found = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!found && kw_cands[k] && tok_len == kw_words[k].len()) begin
        add_token(TK_KEYWORD, 4'(k), tok_line, tok_col, tok_len);
        found = 1'b1;
      end
    end
    if (!found) begin
      add_token(TK_IDENT, NO_KW, tok_line, tok_col, tok_len);
    end
  endfunction

  // Scan a character with no token gathered
  function automatic void scan_fresh(input logic [20:0] c);
    tok_kind_t k;
    cur_mode = MODE_IDLE;
    if (!is_space(c)) begin
      if (is_letter(c)) begin
        start_token(MODE_NAME);
        absorb_letter(c);
      end else if (is_numeral(c)) begin
        start_token(MODE_NUMBER);
        tok_len = 11'd1;
      end else if (c == CH_QUOTE) begin
        start_token(MODE_TEXT);
      end else if (c == CH_COLON) begin
        start_token(MODE_OPERATOR);
        half_op = OP_COLON;
      end else if (c == CH_DOT) begin
        start_token(MODE_OPERATOR);
        half_op = OP_DOT;
      end else begin
        case (c)
          CH_PLUS:   k = TK_PLUS;
          CH_MINUS:  k = TK_MINUS;
          CH_STAR:   k = TK_STAR;
          CH_SLASH:  k = TK_SLASH;
          CH_SEMI:   k = TK_SEMI;
          CH_COMMA:  k = TK_COMMA;
          CH_LPAREN: k = TK_LPAREN;
          CH_RPAREN: k = TK_RPAREN;
          CH_LBRACK: k = TK_LBRACK;
          CH_RBRACK: k = TK_RBRACK;
          default:   k = TK_UNKNOWN;
        endcase
        add_token(k, NO_KW, cur_line, cur_col, 11'd1);
      end
    end
  endfunction

  // Work out the tokens one accepted character causes
  function automatic void predict_tokens(input logic [20:0] c, input logic tlast_bit);
    logic eoi;
    logic taken;
    int   before_n;
    tok_t t;
    eoi      = tlast_bit || (c == CH_NUL);
    taken    = 1'b0;
    before_n = expected_tokens.size();
    if (!scan_done) begin
      case (cur_mode)
        MODE_NAME: begin
          if (!eoi && (is_letter(c) || is_numeral(c)) && tok_len < NAME_CAP) begin
            absorb_letter(c);
            taken = 1'b1;
          end else begin
            close_name();
            cur_mode = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (!eoi && (is_numeral(c) || (c == CH_DOT && !saw_point)) && tok_len < NAME_CAP) begin
            if (c == CH_DOT) saw_point = 1'b1;
            tok_len = tok_len + 11'd1;
            taken   = 1'b1;
          end else begin
            if (saw_point) add_token(TK_REAL, NO_KW, tok_line, tok_col, tok_len);
            else add_token(TK_INTEGER, NO_KW, tok_line, tok_col, tok_len);
            cur_mode = MODE_IDLE;
          end
        end
        MODE_TEXT: begin
          if (!eoi && c == CH_QUOTE) begin
            add_token(TK_STRING, NO_KW, tok_line, tok_col, tok_len);
            cur_mode = MODE_IDLE;
            taken    = 1'b1;
          end else if (!eoi && tok_len < TEXT_CAP) begin
            tok_len = tok_len + 11'd1;
            taken   = 1'b1;
          end else begin
            add_token(TK_UNTERM, NO_KW, tok_line, tok_col, tok_len);
            cur_mode = MODE_IDLE;
          end
        end
        MODE_OPERATOR: begin
          if (half_op == OP_COLON) begin
            if (!eoi && c == CH_EQUAL) begin
              add_token(TK_ASSIGN, NO_KW, tok_line, tok_col, 11'd2);
              taken = 1'b1;
            end else begin
              add_token(TK_COLON, NO_KW, tok_line, tok_col, 11'd1);
            end
          end else begin
            if (!eoi && c == CH_DOT) begin
              add_token(TK_RANGE, NO_KW, tok_line, tok_col, 11'd2);
              taken = 1'b1;
            end else begin
              add_token(TK_DOT, NO_KW, tok_line, tok_col, 11'd1);
            end
          end
          half_op  = OP_NONE;
          cur_mode = MODE_IDLE;
        end
        default: cur_mode = MODE_IDLE;
      endcase

      if (!taken) begin
        if (eoi) begin
          add_token(TK_END, NO_KW, cur_line, cur_col, 11'd0);
          scan_done = 1'b1;
        end else begin
          scan_fresh(c);
        end
      end

      // Advance the position, pinned at the top
      if (!eoi) begin
        if (c == CH_LF) begin
          if (cur_line != POS_MAX) cur_line = cur_line + 16'd1;
          cur_col = 16'd0;
        end else if (cur_col != POS_MAX) begin
          cur_col = cur_col + 16'd1;
        end
      end

      // Mark the final token of this character
      if (expected_tokens.size() > before_n) begin
        t      = expected_tokens.pop_back();
        t.last = 1'b1;
        expected_tokens.push_back(t);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Predict on each input transfer, then check each result transfer
  always @(posedge clk) begin
    tok_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_tokens(in_tdata[20:0], in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d line %0d column %0d length %0d",
                 out_tdata[4:0], out_tdata[24:9], out_tdata[40:25], out_tdata[51:41]);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", int'(want.kind), int'(out_tdata[4:0]));
          check_field("keyword_code", int'(want.kw), int'(out_tdata[8:5]));
          check_field("start_line", int'(want.line), int'(out_tdata[24:9]));
          check_field("start_column", int'(want.col), int'(out_tdata[40:25]));
          check_field("lexeme_length", int'(want.len), int'(out_tdata[51:41]));
          check_field("last_of_run", int'(want.last), int'(out_tlast));
        end
      end
    end
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (!calm) ready_hold = pick_gap();
    end
  end

  // Offer one character and hold it until the transfer
  task automatic send_char(input logic [20:0] c, input logic eoi);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, c};
    in_tlast  <= eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char({13'd0, s[i]}, 1'b0);
  endtask

  task automatic send_repeat(input logic [20:0] c, input int n);
    repeat (n) send_char(c, 1'b0);
  endtask

  // Stop the source and wait until every predicted token is out
  task automatic drain_results();
    int waited;
    in_tvalid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (expected_tokens.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [20:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_LC_A + 21'(r);
    if (r < 52) return CH_UC_A + 21'(r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [20:0] rand_digit();
    return CH_ZERO + 21'($urandom_range(0, 9));
  endfunction

  // Most token kinds, the two-character operators and the widest codes
  task automatic test_token_kinds();
    send_text("x:=1.2;(a..b)[c],'s'+-*/:.");
    send_char(CP_MAX, 1'b0);
    send_char(21'h0FFFFF, 1'b0);
    send_text("7 3..!''");
    send_char(CH_TAB, 1'b0);
    send_char(CH_CR, 1'b0);
    drain_results();
  endtask

  // All keywords, then near misses that must stay identifiers
  task automatic test_keywords();
    for (int k = 0; k < KW_COUNT; k++) begin
      send_text(kw_words[k]);
      send_char(CH_SPACE, 1'b0);
    end
    send_text("Begin endx do1 en procedures\n");
    drain_results();
  endtask

  // Names and numbers split at the cap; strings at and past the text cap
  task automatic test_long_tokens();
    send_repeat(CH_LC_A, NAME_CAP + 1);
    send_char(CH_SPACE, 1'b0);
    send_repeat(CH_NINE, NAME_CAP + 1);
    send_char(CH_SPACE, 1'b0);
    send_text("1.");
    send_repeat(CH_ZERO + 21'd5, NAME_CAP - 1);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_QUOTE, 1'b0);
    send_repeat(CH_LC_Z, TEXT_CAP);
    send_char(CH_QUOTE, 1'b0);
    send_char(CH_QUOTE, 1'b0);
    send_repeat(CH_LC_A + 21'd10, TEXT_CAP + 1);
    send_char(CH_SPACE, 1'b0);
    drain_results();
  endtask

  task automatic send_random_name();
    string w;
    string u;
    int    n;
    w = kw_words[$urandom_range(0, KW_COUNT - 1)];
    case ($urandom_range(0, 4))
      0, 1: send_text(w);
      2: begin
        case ($urandom_range(0, 2))
          0: w = w.substr(0, w.len() - 2);
          1: w = {w, "x"};
          default: begin
            u = w.toupper();
            w = {u.substr(0, 0), w.substr(1, w.len() - 1)};
          end
        endcase
        send_text(w);
      end
      default: begin
        n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        send_char(rand_letter(), 1'b0);
        for (int i = 1; i < n; i++) begin
          send_char(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter(), 1'b0);
        end
      end
    endcase
  endtask

  task automatic send_random_number();
    int n;
    int point_at;
    n        = $urandom_range(1, 8);
    point_at = ($urandom_range(0, 99) < 40) ? $urandom_range(1, n) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == point_at) send_char(CH_DOT, 1'b0);
      send_char(rand_digit(), 1'b0);
    end
    // Occasionally one more point, which ends the number when it already holds one
    if (point_at >= 0 && $urandom_range(0, 3) == 0) begin
      send_char(CH_DOT, 1'b0);
      send_char(rand_digit(), 1'b0);
    end
  endtask

  task automatic send_random_string();
    int          n;
    int          r;
    logic [20:0] c;
    n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 15) : $urandom_range(16, 60);
    send_char(CH_QUOTE, 1'b0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) c = CH_LF;
      else if (r < 14) c = 21'($urandom_range(128, CP_MAX));
      else begin
        c = 21'($urandom_range(32, 126));
        if (c == CH_QUOTE) c = CH_SPACE;
      end
      send_char(c, 1'b0);
    end
    send_char(CH_QUOTE, 1'b0);
  endtask

  task automatic send_random_operator();
    logic [20:0] ops [13] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_SEMI, CH_COMMA,
                              CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_COLON,
                              CH_EQUAL, CH_DOT};
    send_char(ops[$urandom_range(0, 12)], 1'b0);
    // Pair up often so := and .. show up
    case ($urandom_range(0, 5))
      0: send_char(CH_EQUAL, 1'b0);
      1: send_char(CH_DOT, 1'b0);
      default: ;
    endcase
  endtask

  // One token, noise or whitespace, then a random separator or none
  task automatic send_random_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) send_random_name();
    else if (r < 40) send_random_number();
    else if (r < 50) send_random_string();
    else if (r < 75) send_random_operator();
    else if (r < 85) send_char(($urandom_range(0, 1) == 0) ? CH_LF :
                               21'($urandom_range(9, 13)), 1'b0);
    else if ($urandom_range(0, 1) == 0) send_char(21'($urandom_range(1, 127)), 1'b0);
    else send_char(21'($urandom_range(128, CP_MAX)), 1'b0);

    r = $urandom_range(0, 99);
    if (r < 40) ;
    else if (r < 75) send_char(CH_SPACE, 1'b0);
    else if (r < 85) send_char(CH_LF, 1'b0);
    else send_char(21'($urandom_range(9, 13)), 1'b0);
  endtask

  // Random source text, with calm stretches and one full pause midway
  task automatic test_random_source();
    int goal;
    int chunk;
    bit paused;
    goal   = chars_sent + RANDOM_CHARS;
    chunk  = 0;
    paused = 1'b0;
    while (chars_sent < goal) begin
      calm = (chunk % 5 == 3);
      repeat (12) send_random_token();
      chunk++;
      if (!paused && chars_sent >= goal - RANDOM_CHARS / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    calm = 1'b0;
    drain_results();
  endtask

  // Run the column and then the line counter into their ceiling
  task automatic test_position_saturation();
    calm = 1'b1;
    send_char(CH_LF, 1'b0);
    send_repeat(CH_SPACE, 65540);
    send_text("ab c:= 'q'");
    send_char(CH_LF, 1'b0);
    send_text("x1");
    send_repeat(CH_LF, 65540);
    send_text("z 'q' 9.5;");
    send_char(CH_LF, 1'b0);
    send_text("w");
    calm = 1'b0;
    drain_results();
  endtask

  // Leave a random token open, end the source, then feed ignored characters
  task automatic test_end_of_input();
    case ($urandom_range(0, 5))
      0: send_text("'open\ntext");
      1: send_text("name1");
      2: send_text("42.5");
      3: send_text(":");
      4: send_text(".");
      default: send_text(" ");
    endcase
    if ($urandom_range(0, 1) == 0) send_char(21'($urandom_range(0, CP_MAX)), 1'b1);
    else send_char(CH_NUL, 1'b0);
    repeat (20) begin
      send_char(($urandom_range(0, 3) == 0) ? CH_NUL : 21'($urandom_range(1, CP_MAX)),
                1'($urandom_range(0, 1)));
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_token_kinds();
    test_keywords();
    test_long_tokens();
    test_random_source();
    test_position_saturation();
    test_end_of_input();

    if (expected_tokens.size() != 0) begin
      $error("%0d predicted tokens never arrived", expected_tokens.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

[pascal_style_token_scanner.f]
rtl/pst_pkg.sv
rtl/pst_scan.sv
rtl/pascal_style_token_scanner.sv
verif/tb_top.sv
